// ===== rtl/sqlkt_pkg.sv =====
// shared types, token codes and keyword table for the sql keyword tokenizer
`timescale 1ns / 1ps
`default_nettype none
package sqlkt_pkg;

	localparam int DEF_MAX_INPUT_BYTES = 65536;
	localparam int KW_COUNT = 31;
	localparam int FIFO_DEPTH = 8;
	localparam int MAX_TOKENS = 3;
	localparam logic [3:0] STAMP_DATE_DIGITS = 4'd8;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// token kinds
	localparam logic [5:0] K_IDENT = 6'd31;
	localparam logic [5:0] K_NUMBER = 6'd32;
	localparam logic [5:0] K_STAMP = 6'd34;
	localparam logic [5:0] K_STAR = 6'd35;
	localparam logic [5:0] K_COMMA = 6'd36;
	localparam logic [5:0] K_LPAREN = 6'd37;
	localparam logic [5:0] K_RPAREN = 6'd38;
	localparam logic [5:0] K_SEMI = 6'd39;
	localparam logic [5:0] K_GTE = 6'd40;
	localparam logic [5:0] K_LTE = 6'd41;
	localparam logic [5:0] K_EQ = 6'd42;
	localparam logic [5:0] K_END = 6'd43;
	localparam logic [5:0] K_ERROR = 6'd44;

	typedef enum logic [2:0] {
		M_IDLE,
		M_IDENT,
		M_DIGITS,
		M_SIGNED,
		M_FRAC,
		M_STAMP,
		M_GT,
		M_LT
	} mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} tok_t;

	// keywords, right-justified in 80 bits
	localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
		80'("create"), 80'("table"), 80'("insert"), 80'("into"), 80'("values"),
		80'("select"), 80'("from"), 80'("where"), 80'("and"), 80'("limit"),
		80'("update"), 80'("set"), 80'("to"), 80'("alter"), 80'("add"),
		80'("drop"), 80'("column"), 80'("field"), 80'("timestamp"), 80'("float"),
		80'("int"), 80'("day"), 80'("hour"), 80'("minute"), 80'("second"),
		80'("milli"), 80'("micro"), 80'("month"), 80'("merge"), 80'({"max_", "rows"}),
		80'("by")
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd4, 4'd5, 4'd3, 4'd5,
		4'd6, 4'd3, 4'd2, 4'd5, 4'd3, 4'd4, 4'd6, 4'd5, 4'd9, 4'd5,
		4'd3, 4'd3, 4'd4, 4'd6, 4'd6, 4'd5, 4'd5, 4'd5, 4'd5, 4'd8,
		4'd2
	};

endpackage
`default_nettype wire

// ===== rtl/sqlkt_lex.sv =====
// lexer core: state registers and per-byte token decode
`timescale 1ns / 1ps
`default_nettype none
module sqlkt_lex import sqlkt_pkg::*; #(
	parameter int MAX_INPUT_BYTES = DEF_MAX_INPUT_BYTES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] text_byte,
	input  wire logic       final_byte,
	output tok_t            tok [MAX_TOKENS],
	output logic [1:0]      tok_cnt
);

	localparam int PW = $clog2(MAX_INPUT_BYTES);

	mode_t       mode_q, mode_d;
	logic [15:0] pstart_q, pstart_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [15:0] plen_q, plen_d;
	logic [30:0] alive_q, alive_d;
	logic [3:0]  drun_q, drun_d;
	logic [3:0]  sphase_q, sphase_d;

	function automatic logic [30:0] kw_keep(input logic [15:0] pl, input logic [7:0] lc);
		logic [30:0] keep;
		logic [6:0]  base;
		keep = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			base = 7'((KW_LEN[k] - 4'd1 - pl[3:0]) * 8);
			keep[k] = (pl < {12'd0, KW_LEN[k]}) && (KW_TEXT[k][base +: 8] == lc);
		end
		return keep;
	endfunction

	function automatic logic [5:0] kw_kind(input logic [30:0] al, input logic [15:0] pl);
		logic [5:0] kind;
		kind = K_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (al[k] && ({12'd0, KW_LEN[k]} == pl)) begin
				kind = 6'(k);
			end
		end
		return kind;
	endfunction

	function automatic tok_t flush_tok(input mode_t m, input logic [15:0] ps,
			input logic [15:0] pl, input logic [30:0] al);
		tok_t t;
		t.start = ps;
		t.len = pl;
		t.last = 1'b0;
		case (m)
			M_IDENT: t.kind = kw_kind(al, pl);
			M_DIGITS, M_SIGNED, M_FRAC: t.kind = K_NUMBER;
			M_STAMP: t.kind = K_STAMP;
			M_GT, M_LT: begin
				t.kind = K_ERROR;
				t.len = 16'd1;
			end
			default: t.kind = K_IDENT;
		endcase
		return t;
	endfunction

	function automatic logic [15:0] grow(input logic [15:0] pl);
		return (pl == LEN_MAX) ? pl : pl + 16'd1;
	endfunction

	// per-byte decode: pending token, fresh lex, final flush
	always_comb begin
		logic [7:0]  c;
		logic [7:0]  lc;
		logic        dig;
		logic        spc;
		logic        ends;
		logic        taken;
		logic [2:0]  cnt;
		logic [15:0] pos16;
		logic [PW-1:0] nxt;
		tok_t        t;
		tok_t        slot [MAX_TOKENS];

		c = text_byte;
		lc = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
		dig = (c >= 8'd48 && c <= 8'd57);
		spc = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
		ends = spc || c == "," || c == "(" || c == ")" || c == ";" || c == "=" ||
			c == "<" || c == ">";
		pos16 = 16'(pos_q);
		nxt = (pos_q == PW'(MAX_INPUT_BYTES - 1)) ? '0 : pos_q + 1'b1;
		taken = 1'b0;
		cnt = '0;
		for (int i = 0; i < MAX_TOKENS; i++) begin
			slot[i] = '0;
		end
		t = '0;

		mode_d = mode_q;
		pstart_d = pstart_q;
		plen_d = plen_q;
		alive_d = alive_q;
		drun_d = drun_q;
		sphase_d = sphase_q;
		pos_d = nxt;

		// offer the byte to the pending token
		if (mode_q != M_IDLE) begin
			case (mode_q)
				M_IDENT: begin
					if (!ends) begin
						alive_d = alive_q & kw_keep(plen_q, lc);
						plen_d = grow(plen_q);
						taken = 1'b1;
					end
				end
				M_DIGITS: begin
					if (dig) begin
						plen_d = grow(plen_q);
						drun_d = drun_q + 4'd1;
						if (drun_d >= STAMP_DATE_DIGITS) begin
							mode_d = M_STAMP;
							sphase_d = '0;
						end
						taken = 1'b1;
					end else if (c == ".") begin
						plen_d = grow(plen_q);
						mode_d = M_FRAC;
						taken = 1'b1;
					end
				end
				M_SIGNED: begin
					if (dig) begin
						plen_d = grow(plen_q);
						taken = 1'b1;
					end else if (c == ".") begin
						plen_d = grow(plen_q);
						mode_d = M_FRAC;
						taken = 1'b1;
					end
				end
				M_FRAC: begin
					if (dig) begin
						plen_d = grow(plen_q);
						taken = 1'b1;
					end
				end
				M_STAMP: begin
					case (sphase_q)
						4'd0, 4'd9: taken = (c == "-");
						4'd3, 4'd6: taken = (c == ":");
						4'd1, 4'd4, 4'd7: taken = dig && !final_byte;
						4'd2, 4'd5, 4'd8: taken = 1'b1;
						4'd10: taken = dig;
						default: taken = 1'b0;
					endcase
					if (taken) begin
						plen_d = grow(plen_q);
						if (sphase_q != 4'd10) begin
							sphase_d = sphase_q + 4'd1;
						end
					end
				end
				M_GT, M_LT: begin
					if (c == "=") begin
						t.kind = (mode_q == M_GT) ? K_GTE : K_LTE;
						t.start = pstart_q;
						t.len = 16'd2;
						t.last = 1'b0;
						slot[cnt[1:0]] = t;
						cnt = cnt + 3'd1;
						mode_d = M_IDLE;
						taken = 1'b1;
					end
				end
				default: taken = 1'b0;
			endcase
			if (!taken) begin
				slot[cnt[1:0]] = flush_tok(mode_q, pstart_q, plen_q, alive_q);
				cnt = cnt + 3'd1;
				mode_d = M_IDLE;
			end
		end

		// lex the byte afresh
		if (!taken && !spc) begin
			t.start = pos16;
			t.len = 16'd1;
			t.last = 1'b0;
			t.kind = K_ERROR;
			if (c == "," || c == "(" || c == ")" || c == ";" || c == "*" || c == "=" ||
					((c == "<" || c == ">") && final_byte)) begin
				case (c)
					",": t.kind = K_COMMA;
					"(": t.kind = K_LPAREN;
					")": t.kind = K_RPAREN;
					";": t.kind = K_SEMI;
					"*": t.kind = K_STAR;
					"=": t.kind = K_EQ;
					default: t.kind = K_ERROR;
				endcase
				slot[cnt[1:0]] = t;
				cnt = cnt + 3'd1;
			end else begin
				pstart_d = pos16;
				plen_d = 16'd1;
				drun_d = '0;
				sphase_d = '0;
				alive_d = '1;
				if (c == ">") begin
					mode_d = M_GT;
				end else if (c == "<") begin
					mode_d = M_LT;
				end else if (c == "-" || c == "+") begin
					mode_d = M_SIGNED;
				end else if (dig) begin
					mode_d = M_DIGITS;
					drun_d = 4'd1;
				end else begin
					mode_d = M_IDENT;
					alive_d = kw_keep(16'd0, lc);
				end
			end
		end

		// final byte: flush, end token, fresh text
		if (final_byte) begin
			if (mode_d != M_IDLE && cnt < 3'd3) begin
				slot[cnt[1:0]] = flush_tok(mode_d, pstart_d, plen_d, alive_d);
				cnt = cnt + 3'd1;
			end
			if (cnt < 3'd3) begin
				t.kind = K_END;
				t.start = 16'(nxt);
				t.len = 16'd0;
				t.last = 1'b0;
				slot[cnt[1:0]] = t;
				cnt = cnt + 3'd1;
			end
			mode_d = M_IDLE;
			pstart_d = '0;
			plen_d = '0;
			alive_d = '1;
			drun_d = '0;
			sphase_d = '0;
			pos_d = '0;
		end

		if (cnt != 3'd0) begin
			slot[2'(cnt - 3'd1)].last = 1'b1;
		end
		for (int i = 0; i < MAX_TOKENS; i++) begin
			tok[i] = slot[i];
		end
		tok_cnt = 2'(cnt);
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pstart_q <= '0;
			pos_q <= '0;
			plen_q <= '0;
			alive_q <= '1;
			drun_q <= '0;
			sphase_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pstart_q <= pstart_d;
			pos_q <= pos_d;
			plen_q <= plen_d;
			alive_q <= alive_d;
			drun_q <= drun_d;
			sphase_q <= sphase_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sqlkt_fifo.sv =====
// token queue: up to three pushes per cycle, one pop
`timescale 1ns / 1ps
`default_nettype none
module sqlkt_fifo import sqlkt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_cnt,
	input  tok_t            push_tok [MAX_TOKENS],
	output logic            room,
	output logic            pop_valid,
	input  wire logic       pop_ready,
	output tok_t            pop_tok
);

	localparam int AW = $clog2(FIFO_DEPTH);

	tok_t          mem_q [FIFO_DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   count_q;
	logic          pop;

	assign room = count_q <= (AW+1)'(FIFO_DEPTH - MAX_TOKENS);
	assign pop_valid = count_q != '0;
	assign pop = pop_valid && pop_ready;
	assign pop_tok = mem_q[rptr_q];

	// entry writes
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TOKENS; i++) begin
			if (2'(i) < push_cnt) begin
				mem_q[wptr_q + AW'(i)] <= push_tok[i];
			end
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			wptr_q <= wptr_q + AW'(push_cnt);
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (AW+1)'(push_cnt) - (AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sql_keyword_tokenizer.sv =====
// Top level of the sql keyword tokenizer.
// An accepted byte's tokens are registered in the queue and offered from it.
// Throughput: one byte per cycle while the token queue has room for three tokens;
// results leave one token per cycle while out_ready is high; drain sets the rate.
// Reset: arst_n clears lexer state, byte offset and the token queue at once.
`timescale 1ns / 1ps
`default_nettype none
module sql_keyword_tokenizer import sqlkt_pkg::*; #(
	parameter int MAX_INPUT_BYTES = DEF_MAX_INPUT_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  text_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic             run_last
);

	logic       room;
	logic       accept;
	tok_t       toks [MAX_TOKENS];
	logic [1:0] tok_cnt;
	tok_t       head;

	assign in_ready = room;
	assign accept = in_valid && room;

	// byte decode
	sqlkt_lex #(
		.MAX_INPUT_BYTES(MAX_INPUT_BYTES)
	) u_lex (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.text_byte(text_byte),
		.final_byte(final_byte),
		.tok(toks),
		.tok_cnt(tok_cnt)
	);

	// token queue
	sqlkt_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_cnt(accept ? tok_cnt : 2'd0),
		.push_tok(toks),
		.room(room),
		.pop_valid(out_valid),
		.pop_ready(out_ready),
		.pop_tok(head)
	);

	assign token_kind = head.kind;
	assign token_start = head.start;
	assign token_length = head.len;
	assign run_last = head.last;

endmodule
`default_nettype wire

// ===== rtl/sqlkt_checker.sv =====
// port checker for the sql keyword tokenizer and its bind
`timescale 1ns / 1ps
`default_nettype none
module sqlkt_checker import sqlkt_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [5:0]  token_kind,
	input wire logic [15:0] token_length,
	input wire logic        run_last
);

	// a stalled token beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
		$stable(token_length))
		else $error("stalled token changed");

	// end token closes its run with zero length
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_END |-> token_length == 16'd0 && run_last)
		else $error("bad end token");

	// single-byte tokens have length one
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == K_STAR || token_kind == K_COMMA ||
		token_kind == K_LPAREN || token_kind == K_RPAREN || token_kind == K_SEMI ||
		token_kind == K_EQ || token_kind == K_ERROR) |-> token_length == 16'd1)
		else $error("single-byte token length");

	// two-byte comparisons
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == K_GTE || token_kind == K_LTE) |->
		token_length == 16'd2)
		else $error("comparison token length");

endmodule

bind sql_keyword_tokenizer sqlkt_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.token_kind(token_kind),
	.token_length(token_length),
	.run_last(run_last)
);
`default_nettype wire

// ===== test/tb_sql_keyword_tokenizer.sv =====
// self-checking testbench for the sql keyword tokenizer
`timescale 1ns / 1ps
module tb_sql_keyword_tokenizer;
	import sqlkt_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] text_byte;
	logic final_byte;
	logic out_valid;
	logic out_ready;
	logic [5:0] token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic run_last;

	sql_keyword_tokenizer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.text_byte(text_byte), .final_byte(final_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .token_start(token_start),
		.token_length(token_length), .run_last(run_last)
	);

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [5:0] NO_KIND = 6'h3F;

	// lexer state mirrored by the predictor
	mode_t lx_mode;
	logic [15:0] lx_start;
	logic [15:0] lx_pos;
	logic [15:0] lx_len;
	logic [30:0] lx_alive;
	int lx_digits;
	int lx_phase;

	tok_t token_queue [$];
	tok_t step_toks [$];
	int errors;
	int cycles;
	bit stim_done;

	typedef struct {
		logic [7:0] ch;
		logic fin;
		logic [5:0] kind;
		logic [15:0] start;
		logic [15:0] len;
	} row_t;
	row_t rows [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_space(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit ends_ident(logic [7:0] c);
		return is_space(c) || c == "," || c == "(" || c == ")" || c == ";" ||
			c == "=" || c == "<" || c == ">";
	endfunction

	function automatic logic [7:0] kw_char(int k, int i);
		logic [79:0] w;
		w = KW_TEXT[k];
		return w[(KW_LEN[k] - 1 - i) * 8 +: 8];
	endfunction

	function automatic void push_tok(logic [5:0] kind, logic [15:0] start,
		logic [15:0] len);
		tok_t t;
		if (step_toks.size() >= MAX_TOKENS)
			return;
		t.kind = kind;
		t.start = start;
		t.len = len;
		t.last = 1'b0;
		step_toks.insert(step_toks.size(), t);
	endfunction

	function automatic void lengthen();
		if (lx_len != LEN_MAX)
			lx_len++;
	endfunction

	function automatic void ident_char(logic [7:0] c);
		logic [7:0] lc;
		lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		for (int k = 0; k < KW_COUNT; k++)
			if (!(lx_len < KW_LEN[k] && kw_char(k, lx_len) == lc))
				lx_alive[k] = 1'b0;
		lengthen();
	endfunction

	function automatic void close_token();
		logic [5:0] kind;
		kind = K_IDENT;
		case (lx_mode)
			M_IDENT: begin
				for (int k = KW_COUNT - 1; k >= 0; k--)
					if (lx_alive[k] && KW_LEN[k] == lx_len)
						kind = 6'(k);
			end
			M_DIGITS, M_SIGNED, M_FRAC: kind = K_NUMBER;
			M_STAMP: kind = K_STAMP;
			M_GT, M_LT: begin
				kind = K_ERROR;
				lx_len = 16'd1;
			end
			default: begin
				lx_mode = M_IDLE;
				return;
			end
		endcase
		push_tok(kind, lx_start, lx_len);
		lx_mode = M_IDLE;
	endfunction

	task automatic open_mode(mode_t m, logic [15:0] pos);
		lx_mode = m;
		lx_start = pos;
		lx_len = 16'd1;
		lx_digits = 0;
		lx_phase = 0;
		lx_alive = '1;
	endtask

	task automatic fresh_char(logic [7:0] c, bit fin, logic [15:0] pos);
		if (is_space(c))
			return;
		case (c)
			",": begin push_tok(K_COMMA, pos, 1); return; end
			"(": begin push_tok(K_LPAREN, pos, 1); return; end
			")": begin push_tok(K_RPAREN, pos, 1); return; end
			";": begin push_tok(K_SEMI, pos, 1); return; end
			"*": begin push_tok(K_STAR, pos, 1); return; end
			"=": begin push_tok(K_EQ, pos, 1); return; end
			">", "<": begin
				if (fin)
					push_tok(K_ERROR, pos, 1);
				else
					open_mode(c == ">" ? M_GT : M_LT, pos);
				return;
			end
			"-", "+": begin open_mode(M_SIGNED, pos); return; end
			default: ;
		endcase
		if (is_digit(c)) begin
			open_mode(M_DIGITS, pos);
			lx_digits = 1;
			return;
		end
		open_mode(M_IDENT, pos);
		lx_len = 16'd0;
		ident_char(c);
	endtask

	// offer a byte to the open token, returns 1 when it was absorbed
	function automatic bit extend_token(logic [7:0] c, bit fin);
		bit dig;
		dig = is_digit(c);
		case (lx_mode)
			M_IDENT: if (!ends_ident(c)) begin
				ident_char(c);
				return 1;
			end
			M_DIGITS: begin
				if (dig) begin
					lengthen();
					lx_digits++;
					if (lx_digits >= STAMP_DATE_DIGITS) begin
						lx_mode = M_STAMP;
						lx_phase = 0;
					end
					return 1;
				end
				if (c == ".") begin
					lengthen();
					lx_mode = M_FRAC;
					return 1;
				end
			end
			M_SIGNED: begin
				if (dig) begin lengthen(); return 1; end
				if (c == ".") begin
					lengthen();
					lx_mode = M_FRAC;
					return 1;
				end
			end
			M_FRAC: if (dig) begin lengthen(); return 1; end
			M_STAMP: begin
				case (lx_phase)
					0, 9: if (c == "-") begin lengthen(); lx_phase++; return 1; end
					3, 6: if (c == ":") begin lengthen(); lx_phase++; return 1; end
					1, 4, 7: if (dig && !fin) begin lengthen(); lx_phase++; return 1; end
					2, 5, 8: begin lengthen(); lx_phase++; return 1; end
					10: if (dig) begin lengthen(); return 1; end
					default: ;
				endcase
			end
			M_GT, M_LT: if (c == "=") begin
				push_tok(lx_mode == M_GT ? K_GTE : K_LTE, lx_start, 2);
				lx_mode = M_IDLE;
				return 1;
			end
			default: return 0;
		endcase
		close_token();
		return 0;
	endfunction

	task automatic clear_lexer();
		lx_mode = M_IDLE;
		lx_start = '0;
		lx_pos = '0;
		lx_len = '0;
		lx_alive = '1;
		lx_digits = 0;
		lx_phase = 0;
	endtask

	// work out the tokens one byte produces and queue them
	task automatic predict_tokens(logic [7:0] c, bit fin);
		logic [15:0] pos;
		pos = lx_pos;
		step_toks.delete();
		if (lx_mode == M_IDLE || !extend_token(c, fin))
			fresh_char(c, fin, pos);
		if (fin) begin
			close_token();
			push_tok(K_END, pos + 16'd1, 0);
			clear_lexer();
		end else
			lx_pos = pos + 16'd1;
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
		foreach (step_toks[i])
			token_queue.insert(token_queue.size(), step_toks[i]);
	endtask

	task automatic add_row(logic [7:0] c, bit fin, logic [5:0] kind = NO_KIND,
		logic [15:0] start = 0, logic [15:0] len = 0);
		row_t r;
		r.ch = c;
		r.fin = fin;
		r.kind = kind;
		r.start = start;
		r.len = len;
		rows.insert(rows.size(), r);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_row(s[i], i == s.len() - 1);
	endtask

	// random fragment of mostly well-formed tokens
	function automatic string rand_frag();
		string s;
		string punct;
		string kws [8];
		punct = ",()*;=<> \t";
		kws = '{"SELECT", "from", "TimeStamp", {"max_", "rows"}, "by", "milli", "create",
			"xyz9"};
		case ($urandom_range(0, 9))
			0: s = kws[$urandom_range(0, 7)];
			1: s = $sformatf("%0d", $urandom_range(0, 99999));
			2: s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
			3: s = $sformatf("20%06d-%02d:%02d:%02d-%0d", $urandom_range(0, 999999),
				$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
				$urandom_range(0, 999));
			4: s = $sformatf("20%06d-%0d", $urandom_range(0, 999999), $urandom_range(0, 9));
			5: s = ($urandom_range(0, 1) ? ">=" : "<");
			6: s = ($urandom_range(0, 1) ? "-3.5" : "+12");
			7: begin
				s = " ";
				s[0] = punct[$urandom_range(0, 9)];
			end
			8: begin
				s = "x";
				s[0] = 8'($urandom_range(0, 255));
			end
			default: s = " ";
		endcase
		return s;
	endfunction

	// input driver: directed table then random text
	initial begin
		string s;
		int hold;
		arst_n = 1'b0;
		in_valid = 1'b0;
		text_byte = '0;
		final_byte = 1'b0;
		stim_done = 1'b0;
		clear_lexer();
		add_row(",", 0, K_COMMA, 0, 1);
		add_row(8'h00, 0);
		add_row(8'hFF, 0);
		add_row(">", 0);
		add_row(" ", 0, K_ERROR, 3, 1);
		add_row("<", 0);
		add_row("=", 0, K_LTE, 5, 2);
		add_row("<", 1);
		add_text({"Select *,max_", "rows(x);ab=c>=1"});
		add_text("-1.5 12345678-12:34:56-789 7");
		add_text("12345678-1");
		add_text("timestampz byx 1.2.3");
		add_row(">", 1);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int n = 0; rows.size() < 220; n++) begin
			s = rand_frag();
			for (int i = 0; i < s.len(); i++)
				add_row(s[i], 0);
			if ($urandom_range(0, 2) == 0)
				add_row(" ", 0);
			if ($urandom_range(0, 15) == 0)
				add_row(8'($urandom_range(0, 255)), 1);
		end
		add_row(";", 1);
		foreach (rows[i]) begin
			hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (i % 40 < 10)
				hold = 0;
			if (hold > 0) begin
				in_valid <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			in_valid <= 1'b1;
			text_byte <= rows[i].ch;
			final_byte <= rows[i].fin;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			predict_tokens(rows[i].ch, rows[i].fin);
			if (rows[i].kind != NO_KIND) begin
				if (step_toks.size() == 0) begin
					$display("%0t table row %0d: expected %0d/%0d/%0d actual none",
						$time, i, rows[i].kind, rows[i].start, rows[i].len);
					errors++;
				end else if (step_toks[0].kind != rows[i].kind ||
					step_toks[0].start != rows[i].start ||
					step_toks[0].len != rows[i].len) begin
					$display("%0t table row %0d: expected %0d/%0d/%0d actual %0d/%0d/%0d",
						$time, i, rows[i].kind, rows[i].start, rows[i].len,
						step_toks[0].kind, step_toks[0].start, step_toks[0].len);
					errors++;
				end
			end
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// token receiver with random stalls
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// compare each token beat with the oldest prediction
	always @(posedge clk) begin
		tok_t t;
		if (arst_n && out_valid && out_ready) begin
			if (token_queue.size() == 0) begin
				$display("%0t unexpected token: kind %0d start %0d len %0d", $time,
					token_kind, token_start, token_length);
				errors++;
			end else begin
				t = token_queue.pop_front();
				if (t.kind != token_kind) begin
					$display("%0t kind: expected %0d actual %0d", $time, t.kind, token_kind);
					errors++;
				end
				if (t.start != token_start) begin
					$display("%0t start: expected %0d actual %0d", $time, t.start, token_start);
					errors++;
				end
				if (t.len != token_length) begin
					$display("%0t length: expected %0d actual %0d", $time, t.len,
						token_length);
					errors++;
				end
				if (t.last != run_last) begin
					$display("%0t run_last: expected %0d actual %0d", $time, t.last,
						run_last);
					errors++;
				end
			end
		end
	end

	// end of run and watchdog
	initial begin
		errors = 0;
		cycles = 0;
		@(posedge arst_n);
		while (!(stim_done && token_queue.size() == 0) && cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
		end else begin
			repeat (20) @(posedge clk);
			if (errors == 0)
				$display("SUCCESS");
			else
				$display("FAILURE");
		end
		$finish;
	end

endmodule
